>>> src/lnig_pkg.sv
// shared types, constants and helpers for the lattice neighbor index generator
package lnig_pkg;

  localparam int SITE_W = 17;
  localparam int SIDE_W = 9;
  localparam int CNT_W = 17;
  localparam int CFG_W = 17;
  localparam int CFG_IDX_W = 1;
  localparam int LW = 11;
  localparam int PER_W = 13;
  localparam int L7_W = 14;
  localparam int F53_W = 12;
  localparam int DIV_W = 19;
  localparam int DIV3_W = 15;
  localparam int VAL_W = 20;
  localparam int ROW_W = 3;
  localparam int NUM_NBR = 6;
  localparam int FIFO_DEPTH = 4;
  localparam int MAX_SIDE_DEF = 384;
  localparam int MIN_SIDE = 6;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 9'd96;
  localparam logic [CNT_W-1:0] COUNT_RESET = 17'd7168;
  localparam int DIV3_K = 21846;
  localparam int DIV3_SH = 16;
  localparam int DIV3_PW = 2 * DIV3_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIDE_LENGTH = 1'b0,
    REG_SITE_COUNT  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [LW-1:0]    l;
    logic [LW-1:0]    w2;
    logic [F53_W-1:0] f53;
    logic [PER_W-1:0] per;
    logic [L7_W-1:0]  l7;
    logic [CNT_W-1:0] n;
  } lnig_geom_t;

  typedef struct packed {
    logic [SITE_W-1:0] site;
    logic [PER_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              cut_left;
    logic              cut_right;
  } lnig_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lnig_fifo_stat_t;

  // floor(x / 3) by reciprocal, exact below 2^15
  function automatic logic [DIV3_W-2:0] div3(input logic [DIV3_W-1:0] x);
    logic [DIV3_PW-1:0] p;
    p = DIV3_PW'(x) * DIV3_PW'(DIV3_K);
    return p[DIV3_SH+DIV3_W-2:DIV3_SH];
  endfunction

endpackage

>>> src/lnig_div.sv
// pipelined restoring divider, one quotient bit per stage
module lnig_div #(
  parameter int NUM_W = 19,
  parameter int DEN_W = 17
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o,
  output logic [NUM_W-1:0] rem_o
);
  localparam int XW = NUM_W + DEN_W;

  logic [NUM_W-1:0] rem_q [NUM_W];
  logic [NUM_W-1:0] quo_q [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    localparam int K = NUM_W - 1 - s;
    logic [NUM_W-1:0] rem_in;
    logic [NUM_W-1:0] quo_in;
    logic [XW-1:0]    den_sh;
    logic [XW-1:0]    rem_x;
    logic             take;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign den_sh = XW'(den_i) << K;
    assign rem_x  = XW'(rem_in);
    assign take   = rem_x >= den_sh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= take ? NUM_W'(rem_x - den_sh) : rem_in;
        quo_q[s] <= quo_in | (NUM_W'(take) << K);
      end
    end
  end

  assign quo_o = quo_q[NUM_W-1];
  assign rem_o = rem_q[NUM_W-1];
endmodule

>>> src/lnig_front.sv
// front end: takes site words, finds row and column and the wide-row end cuts
module lnig_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  lnig_pkg::lnig_geom_t         geom_i,
  input  logic                         site_valid_i,
  input  logic [lnig_pkg::SITE_W-1:0]  site_i,
  output logic                         push_o,
  output lnig_pkg::lnig_item_t         item_o
);
  import lnig_pkg::*;

  localparam int M3_W = DIV_W + 2;

  logic                     v0_q;
  logic [SITE_W-1:0]        a0_q;
  logic [DIV_W-1:0]         v_sh_q;
  logic [SITE_W-1:0]        a_sh_q [DIV_W];
  logic [1:0]               neg_sh_q [DIV_W];

  logic signed [SITE_W:0]   t1;
  logic signed [SITE_W:0]   t2;
  logic [DIV_W-1:0]         num1;
  logic [DIV_W-1:0]         num2;
  logic [DIV_W-1:0]         quo1, rem1, quo2, rem2, rem_col;

  logic [PER_W-1:0]         cw;
  logic [ROW_W-1:0]         rw;
  logic [PER_W-1:0]         w2_e;
  logic [PER_W-1:0]         l_e;
  logic [M3_W-1:0]          m3a1, m3b1, m3a2, m3b2, l_m;
  logic [DIV_W-1:0]         l7m2;
  logic                     hit1, hit2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v_sh_q <= '0;
    end else if (en_i) begin
      v0_q   <= site_valid_i;
      v_sh_q <= {v_sh_q[DIV_W-2:0], v0_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a0_q        <= site_i;
      a_sh_q[0]   <= a0_q;
      neg_sh_q[0] <= {t2[SITE_W], t1[SITE_W]};
      for (int i = 1; i < DIV_W; i++) begin
        a_sh_q[i]   <= a_sh_q[i-1];
        neg_sh_q[i] <= neg_sh_q[i-1];
      end
    end
  end

  // offsets of the site from the two end positions of a wide row
  always_comb begin
    t1   = signed'((SITE_W+1)'(a0_q)) - signed'((SITE_W+1)'(geom_i.w2));
    t2   = signed'((SITE_W+1)'(a0_q)) - signed'((SITE_W+1)'(geom_i.f53))
           + signed'((SITE_W+1)'(1));
    num1 = t1[SITE_W] ? '0 : DIV_W'(DIV_W'(t1[SITE_W-1:0]) * DIV_W'(3));
    num2 = t2[SITE_W] ? '0 : DIV_W'(DIV_W'(t2[SITE_W-1:0]) * DIV_W'(3));
  end

  lnig_div #(.NUM_W(DIV_W), .DEN_W(PER_W)) u_div_col (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (DIV_W'(a0_q)),
    .den_i (geom_i.per),
    .quo_o (),
    .rem_o (rem_col)
  );

  lnig_div #(.NUM_W(DIV_W), .DEN_W(L7_W)) u_div_left (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (num1),
    .den_i (geom_i.l7),
    .quo_o (quo1),
    .rem_o (rem1)
  );

  lnig_div #(.NUM_W(DIV_W), .DEN_W(L7_W)) u_div_right (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (num2),
    .den_i (geom_i.l7),
    .quo_o (quo2),
    .rem_o (rem2)
  );

  // row walk through the six rows of a supercell
  always_comb begin
    w2_e = PER_W'(geom_i.w2);
    l_e  = PER_W'(geom_i.l);
    cw   = rem_col[PER_W-1:0];
    rw   = '0;
    if (cw >= w2_e) begin
      rw = rw + ROW_W'(1);
      cw = cw - w2_e;
    end
    if (cw >= l_e) begin
      rw = rw + ROW_W'(1);
      cw = cw - l_e;
      if (cw >= w2_e) begin
        rw = rw + ROW_W'(1);
        cw = cw - w2_e;
        if (cw >= w2_e) begin
          rw = rw + ROW_W'(1);
          cw = cw - w2_e;
          if (cw >= l_e) begin
            rw = rw + ROW_W'(1);
            cw = cw - l_e;
            if (cw >= w2_e) begin
              rw = rw + ROW_W'(1);
              cw = cw - w2_e;
            end
          end
        end
      end
    end
    if (rw == ROW_W'(6)) begin
      rw = '0;
    end
  end

  // end position i*7L/9 matches when 3T is a multiple of 7L or just below one
  always_comb begin
    l_m  = M3_W'(geom_i.l);
    l7m2 = DIV_W'(geom_i.l7) - DIV_W'(2);
    m3a1 = M3_W'(M3_W'(quo1) * M3_W'(3));
    m3b1 = M3_W'(m3a1 + M3_W'(3));
    m3a2 = M3_W'(M3_W'(quo2) * M3_W'(3));
    m3b2 = M3_W'(m3a2 + M3_W'(3));
    hit1 = !neg_sh_q[DIV_W-1][0] &&
           (((rem1 == '0) && (m3a1 < l_m)) || ((rem1 >= l7m2) && (m3b1 < l_m)));
    hit2 = !neg_sh_q[DIV_W-1][1] &&
           (((rem2 == '0) && (m3a2 < l_m)) || ((rem2 >= l7m2) && (m3b2 < l_m)));
  end

  always_comb begin
    item_o.site      = a_sh_q[DIV_W-1];
    item_o.col       = cw;
    item_o.row       = rw;
    item_o.cut_left  = hit1;
    item_o.cut_right = hit2;
  end

  assign push_o = en_i && v_sh_q[DIV_W-1];
endmodule

>>> src/lnig_fifo.sv
// short queue between front and back ends
module lnig_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic [DW-1:0]            data_i,
  input  logic                     pop_i,
  output logic [DW-1:0]            data_o,
  output lnig_pkg::lnig_fifo_stat_t stat_o
);
  import lnig_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? ((wr_q == AW'(DEPTH - 1)) ? '0 : AW'(wr_q + AW'(1))) : wr_q;
    rd_d  = pop_i ? ((rd_q == AW'(DEPTH - 1)) ? '0 : AW'(rd_q + AW'(1))) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = CW'(cnt_q + CW'(1));
    end else if (pop_i && !push_i) begin
      cnt_d = CW'(cnt_q - CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rd_q];
  assign stat_o.full  = cnt_q == CW'(DEPTH);
  assign stat_o.empty = cnt_q == '0;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q < CW'(DEPTH))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("queue read while empty");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == CW'($past(cnt_q) + CW'(1)))
    else $error("queue count did not follow a write");
endmodule

>>> src/lnig_back.sv
// back end: neighbor formulas, reduction modulo site count, boundary cuts
module lnig_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lnig_pkg::lnig_geom_t         geom_i,
  input  lnig_pkg::lnig_item_t         item_i,
  input  logic                         avail_i,
  output logic                         pop_o,
  output logic                         nbr_valid_o,
  input  logic                         nbr_ready_i,
  output logic [lnig_pkg::SITE_W-1:0]  nbr_o [lnig_pkg::NUM_NBR]
);
  import lnig_pkg::*;

  logic                 en;
  logic                 p_v_q;
  lnig_item_t           p_item_q;
  logic [PER_W-1:0]     p_c23_q;
  logic [PER_W:0]       p_c32_q;
  logic                 p_cm1_q;
  logic [PER_W-1:0]     c23_w, c3_w;
  logic [PER_W+1:0]     c3x_w;

  logic signed [VAL_W-1:0] a_s, c_s, w2_s, l_s, n_s, c23_s, c32_s, b_s;
  logic signed [VAL_W-1:0] x_s, up_s, dn_s, upv_s, y_s, sd_s;
  logic signed [VAL_W-1:0] nb_v [NUM_NBR];
  logic [DIV_W-1:0]        mag [NUM_NBR];
  logic [NUM_NBR-1:0]      neg;
  logic [DIV_W-1:0]        rem_w [NUM_NBR];

  logic [DIV_W-1:0]        v_sh_q;
  logic [SITE_W-1:0]       a_sh_q [DIV_W];
  logic [NUM_NBR-1:0]      neg_sh_q [DIV_W];
  logic [1:0]              cut_sh_q [DIV_W];

  logic                    out_v_q;
  logic [SITE_W-1:0]       nb_q [NUM_NBR];
  logic [SITE_W-1:0]       res [NUM_NBR];
  logic [SITE_W-1:0]       a_l;
  logic [CNT_W:0]          a_w2;

  assign en    = !out_v_q || nbr_ready_i;
  assign pop_o = en && avail_i;

  always_comb begin
    c23_w = PER_W'(div3(DIV3_W'(item_i.col) << 1));
    c3_w  = PER_W'(div3(DIV3_W'(item_i.col)));
    c3x_w = (PER_W+2)'(c3_w) * (PER_W+2)'(3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q   <= 1'b0;
      v_sh_q  <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      p_v_q   <= avail_i;
      v_sh_q  <= {v_sh_q[DIV_W-2:0], p_v_q};
      out_v_q <= v_sh_q[DIV_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_item_q <= item_i;
      p_c23_q  <= c23_w;
      p_c32_q  <= (PER_W+1)'(((PER_W+2)'(item_i.col) * (PER_W+2)'(3)) >> 1);
      p_cm1_q  <= ((PER_W+2)'(item_i.col) - c3x_w) == (PER_W+2)'(1);
    end
  end

  // neighbor formulas by row and column class
  always_comb begin
    a_s   = signed'(VAL_W'(p_item_q.site));
    c_s   = signed'(VAL_W'(p_item_q.col));
    w2_s  = signed'(VAL_W'(geom_i.w2));
    l_s   = signed'(VAL_W'(geom_i.l));
    n_s   = signed'(VAL_W'(geom_i.n));
    c23_s = signed'(VAL_W'(p_c23_q));
    c32_s = signed'(VAL_W'(p_c32_q));
    b_s   = a_s - c_s;
    x_s   = b_s + w2_s + c32_s;
    dn_s  = b_s + l_s + c23_s;
    upv_s = b_s - w2_s + c23_s;
    y_s   = b_s - l_s + c32_s + n_s;
    up_s  = a_s - w2_s + n_s - signed'(VAL_W'(1));
    sd_s  = a_s + w2_s - signed'(VAL_W'(1));
    for (int j = 0; j < NUM_NBR; j++) begin
      nb_v[j] = a_s;
    end
    case (p_item_q.row)
      ROW_W'(0), ROW_W'(3): begin
        if (p_item_q.row == ROW_W'(3)) begin
          up_s = a_s - w2_s + n_s + signed'(VAL_W'(1));
        end
        if (p_item_q.col[0]) begin
          nb_v[0] = x_s + signed'(VAL_W'(1));
          nb_v[1] = x_s;
          nb_v[2] = a_s - signed'(VAL_W'(1)) + n_s;
        end else begin
          nb_v[0] = a_s + signed'(VAL_W'(1));
          nb_v[1] = x_s + signed'(VAL_W'(1));
          nb_v[2] = x_s;
        end
        nb_v[3] = up_s;
      end
      ROW_W'(1), ROW_W'(4): begin
        nb_v[0] = a_s + signed'(VAL_W'(1));
        if (p_cm1_q) begin
          nb_v[1] = dn_s + signed'(VAL_W'(1));
          nb_v[2] = dn_s;
          nb_v[3] = a_s - signed'(VAL_W'(1)) + n_s;
          nb_v[4] = upv_s + n_s;
          nb_v[5] = upv_s + signed'(VAL_W'(1)) + n_s;
        end else begin
          nb_v[1] = dn_s;
          nb_v[2] = a_s - signed'(VAL_W'(1)) + n_s;
          nb_v[3] = upv_s;
        end
      end
      default: begin
        if (p_item_q.row != ROW_W'(2)) begin
          sd_s = a_s + w2_s + signed'(VAL_W'(1));
        end
        if (p_item_q.col[0]) begin
          nb_v[0] = sd_s;
          nb_v[1] = a_s - signed'(VAL_W'(1)) + n_s;
        end else begin
          nb_v[0] = a_s + signed'(VAL_W'(1));
          nb_v[1] = sd_s;
        end
        nb_v[2] = y_s;
        nb_v[3] = y_s + signed'(VAL_W'(1));
      end
    endcase
    for (int j = 0; j < NUM_NBR; j++) begin
      neg[j] = nb_v[j][VAL_W-1];
      mag[j] = neg[j] ? DIV_W'(-nb_v[j]) : DIV_W'(nb_v[j]);
    end
  end

  for (genvar j = 0; j < NUM_NBR; j++) begin : g_lane
    lnig_div #(.NUM_W(DIV_W), .DEN_W(CNT_W)) u_div_mod (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (mag[j]),
      .den_i (geom_i.n),
      .quo_o (),
      .rem_o (rem_w[j])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_sh_q[0]   <= p_item_q.site;
      neg_sh_q[0] <= neg;
      cut_sh_q[0] <= {p_item_q.cut_left, p_item_q.cut_right};
      for (int i = 1; i < DIV_W; i++) begin
        a_sh_q[i]   <= a_sh_q[i-1];
        neg_sh_q[i] <= neg_sh_q[i-1];
        cut_sh_q[i] <= cut_sh_q[i-1];
      end
      for (int j = 0; j < NUM_NBR; j++) begin
        nb_q[j] <= res[j];
      end
    end
  end

  // sign fix of the remainder, then open boundary cuts
  always_comb begin
    a_l  = a_sh_q[DIV_W-1];
    a_w2 = (CNT_W+1)'(a_l) + (CNT_W+1)'(geom_i.w2);
    for (int j = 0; j < NUM_NBR; j++) begin
      if (neg_sh_q[DIV_W-1][j] && (rem_w[j] != '0)) begin
        res[j] = SITE_W'(geom_i.n - CNT_W'(rem_w[j]));
      end else begin
        res[j] = SITE_W'(rem_w[j]);
      end
    end
    if (a_l < SITE_W'(geom_i.w2)) begin
      res[3] = a_l;
    end
    if (cut_sh_q[DIV_W-1][1]) begin
      res[2] = a_l;
    end
    if (cut_sh_q[DIV_W-1][0]) begin
      res[0] = a_l;
    end
    if ((CNT_W'(a_l) < geom_i.n) && (a_w2 >= (CNT_W+1)'(geom_i.n))) begin
      if (a_l[0]) begin
        res[0] = a_l;
      end else begin
        res[1] = a_l;
      end
    end
  end

  assign nbr_valid_o = out_v_q;
  assign nbr_o       = nb_q;
endmodule

>>> src/lattice_neighbor_index_generator.sv
// lattice neighbor index generator top level
// throughput: one site word per cycle while site_ready_o is high, set by the two bit-per-stage divider pipelines
// a four-word queue between front and back ends absorbs output stalls
// reset: side length 96, site count 7168, all pipelines and the queue empty
// configuration writes go to the side and count registers, then to the registered geometry, before they take effect
module lattice_neighbor_index_generator #(
  parameter int MAX_SIDE = lnig_pkg::MAX_SIDE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lnig_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lnig_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           site_valid_i,
  output logic                           site_ready_o,
  input  logic [lnig_pkg::SITE_W-1:0]    site_i,
  output logic                           nbr_valid_o,
  input  logic                           nbr_ready_i,
  output logic [lnig_pkg::SITE_W-1:0]    neighbor_0_o,
  output logic [lnig_pkg::SITE_W-1:0]    neighbor_1_o,
  output logic [lnig_pkg::SITE_W-1:0]    neighbor_2_o,
  output logic [lnig_pkg::SITE_W-1:0]    neighbor_3_o,
  output logic [lnig_pkg::SITE_W-1:0]    neighbor_4_o,
  output logic [lnig_pkg::SITE_W-1:0]    neighbor_5_o
);
  import lnig_pkg::*;

  logic [SIDE_W-1:0] side_q;
  logic [CNT_W-1:0]  count_q;
  lnig_geom_t        geom_q, geom_d;
  logic              front_en;
  logic              push;
  logic              pop;
  lnig_item_t        item_in, item_out;
  lnig_fifo_stat_t   fifo_stat;
  logic [SITE_W-1:0] nbr [NUM_NBR];

  function automatic lnig_geom_t geom_of(input logic [SIDE_W-1:0] side,
                                         input logic [CNT_W-1:0] cnt);
    lnig_geom_t       g;
    logic [LW-1:0]    l;
    if (side < SIDE_W'(MIN_SIDE)) begin
      l = LW'(MIN_SIDE);
    end else if (LW'(side) > LW'(MAX_SIDE)) begin
      l = LW'(MAX_SIDE);
    end else begin
      l = LW'(side);
    end
    g.l   = l;
    g.w2  = LW'(div3(DIV3_W'(l) << 1));
    g.f53 = F53_W'(div3(DIV3_W'(DIV3_W'(l) * DIV3_W'(5))));
    g.per = PER_W'(div3(DIV3_W'(DIV3_W'(l) * DIV3_W'(14))));
    g.l7  = L7_W'(DIV3_W'(l) * DIV3_W'(7));
    g.n   = (cnt == '0) ? CNT_W'(1) : cnt;
    return g;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q  <= SIDE_RESET;
      count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SIDE_LENGTH: side_q  <= cfg_data_i[SIDE_W-1:0];
        REG_SITE_COUNT:  count_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign geom_d = geom_of(side_q, count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q <= geom_of(SIDE_RESET, COUNT_RESET);
    end else begin
      geom_q <= geom_d;
    end
  end

  assign front_en     = !fifo_stat.full;
  assign site_ready_o = front_en;

  lnig_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (front_en),
    .geom_i       (geom_q),
    .site_valid_i (site_valid_i),
    .site_i       (site_i),
    .push_o       (push),
    .item_o       (item_in)
  );

  lnig_fifo #(.DW($bits(lnig_item_t)), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (item_in),
    .pop_i  (pop),
    .data_o (item_out),
    .stat_o (fifo_stat)
  );

  lnig_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom_q),
    .item_i      (item_out),
    .avail_i     (!fifo_stat.empty),
    .pop_o       (pop),
    .nbr_valid_o (nbr_valid_o),
    .nbr_ready_i (nbr_ready_i),
    .nbr_o       (nbr)
  );

  assign neighbor_0_o = nbr[0];
  assign neighbor_1_o = nbr[1];
  assign neighbor_2_o = nbr[2];
  assign neighbor_3_o = nbr[3];
  assign neighbor_4_o = nbr[4];
  assign neighbor_5_o = nbr[5];
endmodule
